### sv/palette_nearest_color_luv_unit_assert.svh
// Assertion macros for the palette nearest color search unit
`ifndef PALETTE_NEAREST_COLOR_LUV_UNIT_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_LUV_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle
`define PNCL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pncl same-cycle check failed");

// Condition implies consequence in the next cycle
`define PNCL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pncl next-cycle check failed");

`endif

### sv/pncl_pkg.sv
// Types, constants and conversion tables for the palette nearest color search unit
package pncl_pkg;

	localparam int PAL_SIZE  = 256;
	localparam int NUM_BANKS = 2;
	localparam int COMP_W    = 20;
	localparam int ENTRY_W   = 3 * COMP_W;
	localparam int ADDR_W    = $clog2(NUM_BANKS * PAL_SIZE);
	localparam int COMP_MAX  = 2 ** (COMP_W - 1) - 1;
	localparam int COMP_MIN  = -COMP_MAX - 1;

	localparam int LIN_W  = 17;
	localparam int XYZ_W  = 17;
	localparam int ACC_W  = 35;
	localparam int D_W    = 21;
	localparam int DD_W   = 42;
	localparam int NUM_W  = 59;
	localparam int QUO_W  = 24;
	localparam int MA_W   = 36;
	localparam int MB_W   = 23;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SQ_W   = 2 * COMP_W + 2;
	localparam int DIST_W = SQ_W + 2;

	localparam logic [XYZ_W-1:0] XN_Q16 = 17'd62290;
	localparam logic [XYZ_W-1:0] YN_Q16 = 17'd65536;
	localparam logic [XYZ_W-1:0] ZN_Q16 = 17'd71357;
	localparam logic [D_W-1:0]   DN_Q16 = D_W'(XN_Q16) + D_W'(15 * YN_Q16) + D_W'(3 * ZN_Q16);

	localparam int KAPPA_Q   = 24389;
	localparam int EPS_LIMIT = 216 * 65536;
	localparam int LDIV_DEN  = 27 * 65536;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_RGB   = 2'd1,
		REQ_INDEX = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SRC, S_MAT, S_CHK, S_CBRT, S_LFIN, S_LDONE, S_D,
		S_MU1, S_MU2, S_MU3, S_MU4, S_MV1, S_MV2, S_MV3, S_MV4,
		S_DIV, S_UV1, S_UV2, S_UV3, S_WRITE, S_SCAN, S_DONE
	} state_t;

	typedef logic [LIN_W-1:0] gamma_lut_t [256];
	typedef logic [15:0] coef_arr_t [9];

	localparam coef_arr_t MAT_COEF = '{
		16'd27031, 16'd23434, 16'd11825,
		16'd13938, 16'd46868, 16'd4730,
		16'd1267,  16'd7811,  16'd62279
	};

	function automatic longint unsigned pow5_q30(input longint unsigned r);
		longint unsigned r2;
		longint unsigned r4;
		r2 = (r * r) >> 30;
		r4 = (r2 * r2) >> 30;
		return (r4 * r) >> 30;
	endfunction

	function automatic gamma_lut_t build_gamma_lut();
		gamma_lut_t lut;
		longint unsigned cc;
		longint unsigned t;
		longint unsigned r;
		longint unsigned cand;
		longint unsigned t2;
		longint unsigned r2;
		longint unsigned v;
		for (int c = 0; c < 256; c++) begin
			cc = 64'(c);
			if (cc <= 64'd10) begin
				v = (cc * 64'd6553600 + 64'd164730) / 64'd329460;
			end else begin
				t = ((cc * 64'd1000 + 64'd14025) << 30) / 64'd269025;
				r = 64'd0;
				for (int b = 30; b >= 0; b--) begin
					cand = r | (64'd1 << b);
					if (pow5_q30(cand) <= t) begin
						r = cand;
					end
				end
				t2 = (t * t) >> 30;
				r2 = (r * r) >> 30;
				v = (((t2 * r2) >> 30) + 64'd8192) >> 14;
			end
			lut[c] = LIN_W'(v);
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

	function automatic logic signed [COMP_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] m;
		logic signed [PROD_W:0] v;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		m = (mag + PROD_W'(32768)) >> 16;
		v = p[PROD_W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
		if (v > COMP_MAX) begin
			return COMP_W'(COMP_MAX);
		end
		if (v < COMP_MIN) begin
			return COMP_W'(COMP_MIN);
		end
		return COMP_W'(v);
	endfunction

endpackage

### sv/pncl_ram.sv
// Generic single write port, single read port RAM with registered read
module pncl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/palette_nearest_color_luv_unit.sv
// Palette nearest color search in CIE LUV: top level
//
// Input channel (in_valid/in_ready) takes one request per transfer:
//   load     - converts red/green/blue to LUV and writes it to entry_index of bank
//   RGB      - converts the color and searches entries 1..255 of bank
//   index    - takes entry entry_index of the other bank and searches bank; index 0 returns 0
// Output channel (out_valid/out_ready) returns match_index for each query;
// a load returns nothing, request type three is dropped.
// One request is processed at a time. A load runs a matrix pass on the shared
// multiplier, then a cube root (or a divide for dark colors) and two divides on the
// shared divider; a color with zero XYZ skips all steps after the matrix pass.
// An RGB query adds the scan of 255 entries from the palette RAM, one per cycle.
// The result sits in an output register, so the next request is taken while it
// waits; a query result that finds the register still full holds until it drains.
// Reset clears the control state; palette RAM contents are undefined until loaded.
module palette_nearest_color_luv_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic       bank,
	input  logic [7:0] entry_index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] match_index
);

	import pncl_pkg::*;

	state_t state_q, state_d;
	state_t div_ret_q, div_ret;

	req_t       req_q;
	logic       bank_q;
	logic [7:0] idx_q;

	logic [LIN_W-1:0] lin_q [3];
	logic [XYZ_W-1:0] xyz_q [3];
	logic [ACC_W-1:0] acc_q, acc_sum, acc_rnd;
	logic [1:0]       row_q, col_q, ph_q;
	logic [3:0]       k_q;

	logic [16:0] c_q, cand;
	logic [4:0]  bit_q;
	logic        cbrt_ok;
	logic [23:0] lbig;

	logic signed [16:0] l_q;
	logic [D_W-1:0]     d_q;
	logic [37:0]        p1_q;
	logic signed [38:0] diff_q;
	logic [38:0]        diff_mag;
	logic [DD_W-1:0]    dd_q;

	logic [DD_W-1:0]       rem_q, den_q, rem_nx;
	logic [DD_W:0]         rem_sh;
	logic                  ge;
	logic [QUO_W-1:0]      dsh_q;
	logic                  neg_q;
	logic [4:0]            dcnt_q;
	logic signed [QUO_W:0] quo_s, du_q, dv_q;
	logic                  div_go, div_neg;
	logic [NUM_W-1:0]      div_num;
	logic [DD_W-1:0]       div_den;

	logic signed [COMP_W-1:0] luv_q [3];

	logic signed [MA_W-1:0]   mul_a, l13;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic [8:0]            scan_cnt_q;
	logic                  v_s1_q, v_s2_q;
	logic [7:0]            idx_s1_q, idx_s2_q;
	logic signed [COMP_W:0] ediff [3];
	logic [SQ_W-1:0]       dsq [3];
	logic [SQ_W-1:0]       sq_s2_q [3];
	logic [DIST_W-1:0]     dist_sum, best_q;
	logic                  found_q;
	logic [7:0]            best_idx_q, res_q, match_q;
	logic                  out_valid_q, out_load;

	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	pncl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_BANKS * PAL_SIZE)
	) u_palette_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr({bank_q, idx_q}),
		.wdata({luv_q[0], luv_q[1], luv_q[2]}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cand     = c_q | (17'd1 << bit_q);
	assign cbrt_ok  = prod_q <= $signed({{(PROD_W - 49){1'b0}}, xyz_q[1], 32'd0});
	assign lbig     = 24'd116 * 24'(c_q) + 24'd128;
	assign acc_sum  = acc_q + prod_q[ACC_W-1:0];
	assign acc_rnd  = acc_sum + ACC_W'(32768);
	assign diff_mag = diff_q[38] ? 39'(-diff_q) : 39'(diff_q);
	assign l13      = MA_W'(l_q) * 13;

	assign rem_sh = {rem_q, dsh_q[QUO_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? DD_W'(rem_sh - {1'b0, den_q}) : DD_W'(rem_sh);
	assign quo_s  = neg_q ? -$signed({1'b0, dsh_q}) : $signed({1'b0, dsh_q});

	assign dist_sum = DIST_W'(sq_s2_q[0]) + DIST_W'(sq_s2_q[1]) + DIST_W'(sq_s2_q[2]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ediff[i] = $signed({luv_q[i][COMP_W-1], luv_q[i]})
				- $signed({ram_rdata[(2 - i) * COMP_W + COMP_W - 1],
					ram_rdata[(2 - i) * COMP_W +: COMP_W]});
			dsq[i] = ediff[i] * ediff[i];
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = {bank_q, scan_cnt_q[7:0]};
		mul_a     = '0;
		mul_b     = '0;
		div_go    = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_neg   = 1'b0;
		div_ret   = S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = {~bank, entry_index};
				if (in_valid) begin
					unique case (req_t'(req_type)) inside
						REQ_LOAD, REQ_RGB: state_d = S_MAT;
						REQ_INDEX: begin
							if (entry_index == 8'd0) begin
								state_d = S_DONE;
							end else begin
								ram_re  = 1'b1;
								state_d = S_SRC;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SRC: state_d = S_WRITE;
			S_MAT: begin
				mul_a = MA_W'(lin_q[col_q]);
				mul_b = MB_W'(MAT_COEF[k_q]);
				if (ph_q == 2'd1 && k_q == 4'd8) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (xyz_q[0] == '0 && xyz_q[1] == '0 && xyz_q[2] == '0) begin
					state_d = S_WRITE;
				end else if ((32'(xyz_q[1]) * 32'(KAPPA_Q)) > 32'(EPS_LIMIT)) begin
					state_d = S_CBRT;
				end else begin
					div_go  = 1'b1;
					div_num = ((NUM_W'(xyz_q[1]) * NUM_W'(KAPPA_Q)) << 8)
						+ NUM_W'(LDIV_DEN / 2);
					div_den = DD_W'(LDIV_DEN);
					div_ret = S_LDONE;
					state_d = S_DIV;
				end
			end
			S_CBRT: begin
				if (ph_q == 2'd0) begin
					mul_a = MA_W'(cand);
					mul_b = MB_W'(cand);
				end else begin
					mul_a = MA_W'(prod_q[33:0]);
					mul_b = MB_W'(cand);
				end
				if (ph_q == 2'd2 && bit_q == 5'd0) begin
					state_d = S_LFIN;
				end
			end
			S_LFIN, S_LDONE: state_d = S_D;
			S_D: state_d = S_MU1;
			S_MU1: begin
				mul_a   = MA_W'(xyz_q[0]);
				mul_b   = MB_W'(DN_Q16);
				state_d = S_MU2;
			end
			S_MU2: begin
				mul_a   = MA_W'(XN_Q16);
				mul_b   = MB_W'(d_q);
				state_d = S_MU3;
			end
			S_MU3: begin
				mul_a   = MA_W'(d_q);
				mul_b   = MB_W'(DN_Q16);
				state_d = S_MU4;
			end
			S_MU4: begin
				div_go  = 1'b1;
				div_num = (NUM_W'(diff_mag) << 18) + NUM_W'(prod_q[DD_W-1:1]);
				div_den = prod_q[DD_W-1:0];
				div_neg = diff_q[38];
				div_ret = S_MV1;
				state_d = S_DIV;
			end
			S_MV1: begin
				mul_a   = MA_W'(xyz_q[1]);
				mul_b   = MB_W'(DN_Q16);
				state_d = S_MV2;
			end
			S_MV2: begin
				mul_a   = MA_W'(YN_Q16);
				mul_b   = MB_W'(d_q);
				state_d = S_MV3;
			end
			S_MV3: state_d = S_MV4;
			S_MV4: begin
				div_go  = 1'b1;
				div_num = (((NUM_W'(diff_mag) << 3) + NUM_W'(diff_mag)) << 16)
					+ NUM_W'(dd_q[DD_W-1:1]);
				div_den = dd_q;
				div_neg = diff_q[38];
				div_ret = S_UV1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (dcnt_q == 5'd0) begin
					state_d = div_ret_q;
				end
			end
			S_UV1: begin
				mul_a   = l13;
				mul_b   = MB_W'(du_q);
				state_d = S_UV2;
			end
			S_UV2: begin
				mul_a   = l13;
				mul_b   = MB_W'(dv_q);
				state_d = S_UV3;
			end
			S_UV3: state_d = S_WRITE;
			S_WRITE: begin
				if (req_q == REQ_LOAD) begin
					ram_we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!scan_cnt_q[8]) begin
					ram_re = 1'b1;
				end else if (!v_s1_q && !v_s2_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1_q  <= (state_q == S_SCAN) && !scan_cnt_q[8];
			v_s2_q  <= v_s1_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q   <= mul_a * mul_b;
		idx_s2_q <= idx_s1_q;
		for (int i = 0; i < 3; i++) begin
			sq_s2_q[i] <= dsq[i];
		end

		if (div_go) begin
			rem_q     <= DD_W'(div_num[NUM_W-1:QUO_W]);
			dsh_q     <= div_num[QUO_W-1:0];
			den_q     <= div_den;
			neg_q     <= div_neg;
			dcnt_q    <= 5'(QUO_W - 1);
			div_ret_q <= div_ret;
		end else if (state_q == S_DIV) begin
			rem_q  <= rem_nx;
			dsh_q  <= {dsh_q[QUO_W-2:0], ge};
			dcnt_q <= dcnt_q - 5'd1;
		end

		if (out_load) begin
			match_q <= res_q;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_q    <= req_t'(req_type);
					bank_q   <= bank;
					idx_q    <= entry_index;
					lin_q[0] <= GAMMA_LUT[red];
					lin_q[1] <= GAMMA_LUT[green];
					lin_q[2] <= GAMMA_LUT[blue];
					acc_q    <= '0;
					k_q      <= '0;
					row_q    <= '0;
					col_q    <= '0;
					ph_q     <= '0;
					c_q      <= '0;
					bit_q    <= 5'd16;
					res_q    <= '0;
				end
			end
			S_SRC: begin
				for (int i = 0; i < 3; i++) begin
					luv_q[i] <= ram_rdata[(2 - i) * COMP_W +: COMP_W];
				end
			end
			S_MAT: begin
				if (ph_q == 2'd0) begin
					ph_q <= 2'd1;
				end else begin
					ph_q <= 2'd0;
					k_q  <= k_q + 4'd1;
					if (col_q == 2'd2) begin
						xyz_q[row_q] <= acc_rnd[16 +: XYZ_W];
						acc_q        <= '0;
						col_q        <= '0;
						row_q        <= row_q + 2'd1;
					end else begin
						acc_q <= acc_sum;
						col_q <= col_q + 2'd1;
					end
				end
			end
			S_CHK: begin
				for (int i = 0; i < 3; i++) begin
					luv_q[i] <= '0;
				end
			end
			S_CBRT: begin
				if (ph_q == 2'd2) begin
					ph_q  <= 2'd0;
					bit_q <= bit_q - 5'd1;
					if (cbrt_ok) begin
						c_q <= cand;
					end
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end
			S_LFIN:  l_q <= $signed({1'b0, lbig[23:8]}) - 17'sd4096;
			S_LDONE: l_q <= 17'(quo_s);
			S_D: begin
				d_q <= D_W'(xyz_q[0]) + (D_W'(xyz_q[1]) << 4) - D_W'(xyz_q[1])
					+ (D_W'(xyz_q[2]) << 1) + D_W'(xyz_q[2]);
			end
			S_MU2, S_MV2: p1_q <= prod_q[37:0];
			S_MU3, S_MV3: diff_q <= $signed({1'b0, p1_q}) - $signed({1'b0, prod_q[37:0]});
			S_MU4: dd_q <= prod_q[DD_W-1:0];
			S_MV1: du_q <= quo_s;
			S_UV1: dv_q <= quo_s;
			S_UV2: luv_q[1] <= round_sat(prod_q);
			S_UV3: begin
				luv_q[2] <= round_sat(prod_q);
				luv_q[0] <= COMP_W'(l_q);
			end
			S_WRITE: begin
				scan_cnt_q <= 9'd1;
				found_q    <= 1'b0;
			end
			S_SCAN: begin
				idx_s1_q <= scan_cnt_q[7:0];
				res_q    <= best_idx_q;
				if (!scan_cnt_q[8]) begin
					scan_cnt_q <= scan_cnt_q + 9'd1;
				end
				if (v_s2_q && (!found_q || dist_sum < best_q)) begin
					found_q    <= 1'b1;
					best_q     <= dist_sum;
					best_idx_q <= idx_s2_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign match_index = match_q;

	`include "palette_nearest_color_luv_unit_assert.svh"

	`PNCL_ASSERT_SAME(a_idle_scan_empty, state_q == S_IDLE, !v_s1_q && !v_s2_q)
	`PNCL_ASSERT_SAME(a_scan_idx_nonzero, v_s2_q, idx_s2_q != 8'd0)
	`PNCL_ASSERT_NEXT(a_out_from_done, !out_valid_q && state_q != S_DONE, !out_valid_q)

endmodule

### tb/sv/palette_nearest_color_luv_unit_tb.sv
// Self-checking testbench for the palette nearest color search unit in CIE LUV
module palette_nearest_color_luv_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pncl_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = REQ_NONE;
	logic       bank = 1'b0;
	logic [7:0] entry_index = 8'd0;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] match_index;

	typedef struct {
		req_t       rq;
		logic       bk;
		logic [7:0] ix;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		int         typed;
	} stim_row_t;

	int         luv_store [2][256][3];
	logic [7:0] match_due [$];
	int         mismatches = 0;
	bit         gaps_on = 1'b1;

	palette_nearest_color_luv_unit u_top (.*);

	always #1 clk = ~clk;

	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint unsigned srgb_to_linear(input int c);
		longint unsigned cc, t, root, cand, a2, a4, t2, r2;
		cc = longint'(c);
		if (cc <= 10)
			return (cc * 6553600 + 164730) / 329460;
		t = ((cc * 1000 + 14025) << 30) / 269025;
		root = 0;
		for (int k = 30; k >= 0; k--) begin
			cand = root | (64'd1 << k);
			a2 = (cand * cand) >> 30;
			a4 = (a2 * a2) >> 30;
			if (((a4 * cand) >> 30) <= t)
				root = cand;
		end
		t2 = (t * t) >> 30;
		r2 = (root * root) >> 30;
		return (((t2 * r2) >> 30) + 8192) >> 14;
	endfunction

	function automatic longint rnd_div(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic int clamp_comp(input longint v);
		if (v > COMP_MAX)
			return COMP_MAX;
		if (v < COMP_MIN)
			return COMP_MIN;
		return int'(v);
	endfunction

	function automatic void color_to_luv(input int r, input int g, input int b, output int luv[3]);
		longint lr, lg, lb, x, y, z, l, d, dn, du, dv;
		longint unsigned tgt, cr, cand;
		lr = srgb_to_linear(r);
		lg = srgb_to_linear(g);
		lb = srgb_to_linear(b);
		x = (27031 * lr + 23434 * lg + 11825 * lb + 32768) >>> 16;
		y = (13938 * lr + 46868 * lg + 4730 * lb + 32768) >>> 16;
		z = (1267 * lr + 7811 * lg + 62279 * lb + 32768) >>> 16;
		if (x == 0 && y == 0 && z == 0) begin
			luv[0] = 0;
			luv[1] = 0;
			luv[2] = 0;
			return;
		end
		if (y * 24389 > 216 * 65536) begin
			tgt = longint'(y) << 32;
			cr = 0;
			for (int k = 16; k >= 0; k--) begin
				cand = cr | (64'd1 << k);
				if (cand * cand * cand <= tgt)
					cr = cand;
			end
			l = longint'((116 * cr + 128) >> 8) - 4096;
		end else begin
			l = rnd_div(24389 * y * 256, 27 * 65536);
		end
		d = x + 15 * y + 3 * z;
		dn = 62290 + 15 * 65536 + 3 * 71357;
		du = rnd_div(4 * (x * dn - 62290 * d) * 65536, d * dn);
		dv = rnd_div(9 * (y * dn - 65536 * d) * 65536, d * dn);
		luv[0] = clamp_comp(l);
		luv[1] = clamp_comp(rnd_div(13 * l * du, 65536));
		luv[2] = clamp_comp(rnd_div(13 * l * dv, 65536));
	endfunction

	function automatic logic [7:0] nearest_entry(input int bk, input int q[3]);
		longint unsigned best, sum_sq, df;
		int best_ix;
		best = 0;
		best_ix = 0;
		for (int i = 1; i < 256; i++) begin
			sum_sq = 0;
			for (int c = 0; c < 3; c++) begin
				df = longint'(q[c]) - longint'(luv_store[bk][i][c]);
				if (longint'(df) < 0)
					df = -df;
				sum_sq += df * df;
			end
			if (best_ix == 0 || sum_sq < best) begin
				best = sum_sq;
				best_ix = i;
			end
		end
		return 8'(best_ix);
	endfunction

	function automatic void apply_request(input stim_row_t s, output bit has, output logic [7:0] m);
		int q[3];
		has = 1'b0;
		m = 8'd0;
		case (s.rq)
			REQ_LOAD: begin
				color_to_luv(s.r, s.g, s.b, q);
				luv_store[s.bk][s.ix] = q;
			end
			REQ_RGB: begin
				color_to_luv(s.r, s.g, s.b, q);
				has = 1'b1;
				m = nearest_entry(s.bk, q);
			end
			REQ_INDEX: begin
				has = 1'b1;
				if (s.ix != 0) begin
					q = luv_store[!s.bk][s.ix];
					m = nearest_entry(s.bk, q);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input stim_row_t s);
		bit has;
		logic [7:0] m;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= s.rq;
		bank <= s.bk;
		entry_index <= s.ix;
		red <= s.r;
		green <= s.g;
		blue <= s.b;
		do @(posedge clk); while (!in_ready);
		apply_request(s, has, m);
		if (has)
			match_due.push_back(s.typed >= 0 ? 8'(s.typed) : m);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			1: return 8'($urandom_range(0, 12));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic stim_row_t mk(req_t rq, logic bk, logic [7:0] ix, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, int typed);
		stim_row_t s;
		s.rq = rq; s.bk = bk; s.ix = ix; s.r = r; s.g = g; s.b = b; s.typed = typed;
		return s;
	endfunction

	// drain side: check each transfer, stall in bursts
	always @(posedge clk) begin
		int stall;
		logic [7:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (match_due.size() == 0) begin
					$error("match_index: no result expected, actual %0d", match_index);
					mismatches++;
				end else begin
					want = match_due.pop_front();
					if (match_index !== want) begin
						$error("match_index: expected %0d, actual %0d", want, match_index);
						mismatches++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 10) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		stim_row_t dir_rows [$];
		int k;
		int cnt;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both banks so every search reads written entries
		for (int bk = 0; bk < 2; bk++)
			for (int i = 0; i < 256; i++)
				send_item(mk(REQ_LOAD, bk[0], 8'(i), rand_chan(), rand_chan(), rand_chan(), -1));

		dir_rows = '{
			mk(REQ_LOAD,  1'b0, 8'd1,   8'd0,   8'd0,   8'd0,   -1),
			mk(REQ_RGB,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,    1),
			mk(REQ_LOAD,  1'b1, 8'd255, 8'd255, 8'd255, 8'd255, -1),
			mk(REQ_LOAD,  1'b1, 8'd1,   8'd255, 8'd255, 8'd255, -1),
			mk(REQ_RGB,   1'b1, 8'd77,  8'd255, 8'd255, 8'd255,  1),
			mk(REQ_RGB,   1'b0, 8'd0,   8'd255, 8'd0,   8'd0,   -1),
			mk(REQ_RGB,   1'b1, 8'd0,   8'd0,   8'd255, 8'd0,   -1),
			mk(REQ_RGB,   1'b0, 8'd0,   8'd0,   8'd0,   8'd255, -1),
			mk(REQ_RGB,   1'b1, 8'd0,   8'd10,  8'd11,  8'd1,   -1),
			mk(REQ_LOAD,  1'b0, 8'd0,   8'd200, 8'd30,  8'd90,  -1),
			mk(REQ_LOAD,  1'b0, 8'd128, 8'd10,  8'd10,  8'd10,  -1),
			mk(REQ_INDEX, 1'b0, 8'd0,   8'd255, 8'd255, 8'd255,  0),
			mk(REQ_INDEX, 1'b1, 8'd0,   8'd0,   8'd0,   8'd0,    0),
			mk(REQ_INDEX, 1'b0, 8'd255, 8'd0,   8'd0,   8'd0,   -1),
			mk(REQ_INDEX, 1'b1, 8'd1,   8'd3,   8'd4,   8'd5,   -1),
			mk(REQ_INDEX, 1'b1, 8'd128, 8'd0,   8'd0,   8'd0,   -1),
			mk(REQ_NONE,  1'b1, 8'd255, 8'd255, 8'd255, 8'd255, -1),
			mk(REQ_RGB,   1'b0, 8'd255, 8'd12,  8'd11,  8'd10,  -1),
			mk(REQ_RGB,   1'b1, 8'd0,   8'd128, 8'd64,  8'd32,  -1)
		};
		foreach (dir_rows[i])
			send_item(dir_rows[i]);

		cnt = 1400;
		for (int n = 0; n < cnt; n++) begin
			if (n > cnt - 150)
				gaps_on = 1'b0;
			k = $urandom_range(0, 99);
			if (k < 35)
				send_item(mk(REQ_LOAD, 1'($urandom), 8'($urandom), rand_chan(), rand_chan(),
					rand_chan(), -1));
			else if (k < 70)
				send_item(mk(REQ_RGB, 1'($urandom), 8'($urandom), rand_chan(), rand_chan(),
					rand_chan(), -1));
			else if (k < 95)
				send_item(mk(REQ_INDEX, 1'($urandom), $urandom_range(0, 15) == 0 ? 8'd0 :
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), -1));
			else
				send_item(mk(REQ_NONE, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), -1));
		end
		in_valid <= 1'b0;

		while (match_due.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
